FILE: sv/ira_pkg.sv
package ira_pkg;

	localparam int GROUP_SIZE   = 64;
	localparam int ID_COUNT_DEF = 4096;
	localparam int DATA_WIDTH   = 32;

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_REMOVE  = 3'd1;
	localparam logic [2:0] OP_FIND    = 3'd2;
	localparam logic [2:0] OP_REPLACE = 3'd3;
	localparam logic [2:0] OP_NEXT    = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NONE  = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	// Index of the lowest set bit of a 64-bit word; 63 when the word is zero.
	function automatic logic [5:0] lowbit(input logic [63:0] x);
		logic [5:0] n;
		n = 6'd63;
		for (int i = 63; i >= 0; i--) begin
			if (x[i]) begin
				n = 6'(i);
			end
		end
		return n;
	endfunction

endpackage

FILE: sv/id_radix_allocator.sv
// Channel  | Ports                                   | Handshake
// request  | operation, id, data                     | start high while busy low
// result   | status, id_out, data_out, hit, now_empty | done high for one cycle
//
// A request passes through these steps after acceptance: picking a group from
// the summary words, the bitmap memory read, then the data memory read, after
// which done is shown. Find-next reads a second bitmap row when it moves to a
// later group. Requests finished in the summary step (range, full, unused code,
// clear, a find-next start past the top) skip both reads; those refused after
// the bitmap read (ID not allocated, nothing found) skip the data read. A new
// request can be accepted in the cycle that shows done.
// Reset clears the summaries and the row valid bits at once; no clearing pass.
// The result side cannot stall; busy stays high until the result is shown.
module id_radix_allocator
	import ira_pkg::*;
#(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [12:0] id,
	input  logic [31:0] data,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] id_out,
	output logic [31:0] data_out,
	output logic        hit,
	output logic        now_empty
);

	// Group count, index widths, and the masks of real groups and of real IDs in the last group.
	localparam int NG   = (ID_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int IDW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int REM  = ID_COUNT % GROUP_SIZE;
	localparam logic [5:0] LASTG = 6'(NG - 1);
	localparam logic [63:0] WMASK = (NG >= 64) ? {64{1'b1}} : ((64'd1 << NG) - 64'd1);
	localparam logic [63:0] LMASK = (REM == 0) ? {64{1'b1}} : ((64'd1 << REM) - 64'd1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_BMP  = 2'd2;
	localparam logic [1:0] ST_DAT  = 2'd3;

	logic [1:0]  st_q;
	logic [2:0]  op_q;
	logic [12:0] id_q;
	logic [31:0] din_q;
	logic [5:0]  g_q;
	logic [5:0]  b_q;
	logic        second_q;
	logic [63:0] word_q;
	logic [63:0] full_q;
	logic [63:0] nonempty_q;
	logic [NG-1:0] row_vld_q;

	// Bitmap rows and data words live in synchronous memories.
	logic [63:0] bmp_mem [NG];
	logic [31:0] dat_mem [ID_COUNT];
	logic [63:0] bmp_rd_s2;
	logic        bmp_v_s2;
	logic [31:0] dat_rd_s3;

	logic        bmp_re;
	logic [5:0]  bmp_ra;
	logic        bmp_we;
	logic        dat_re;
	logic [11:0] dat_ra;
	logic [11:0] dat_wa;
	logic        dat_we;

	logic        done_q;
	logic [1:0]  status_q;
	logic [11:0] id_out_q;
	logic [31:0] data_out_q;
	logic        hit_q;
	logic        now_empty_q;

	// Decoding of the latched request.
	logic        in_range;
	logic [12:0] nstart;
	logic        nstart_ok;
	logic [63:0] free_grp;
	logic [63:0] row;
	logic [63:0] gmask;
	logic [63:0] bitmask;
	logic [63:0] above;
	logic [63:0] ne_above;
	logic [5:0]  bsel;
	logic [63:0] new_word;
	logic [63:0] gbit;
	logic [63:0] full_nx;
	logic [63:0] nonempty_nx;

	assign in_range  = !id_q[12] && ({8'd0, id_q[11:0]} < 20'(ID_COUNT));
	assign nstart    = id_q[12] ? 13'd0 : ({1'b0, id_q[11:0]} + 13'd1);
	assign nstart_ok = {7'd0, nstart} < 20'(ID_COUNT);
	assign free_grp  = ~full_q & WMASK;

	// A row whose valid bit is clear reads as all zero.
	assign row     = bmp_v_s2 ? bmp_rd_s2 : 64'd0;
	assign gmask   = (REM != 0 && g_q == LASTG) ? LMASK : {64{1'b1}};
	assign bitmask = {64{1'b1}} << b_q;
	// Groups strictly above the current one; shifting past bit 63 gives none.
	assign above    = ~((64'd2 << g_q) - 64'd1);
	assign ne_above = nonempty_q & WMASK & above;

	always_comb begin
		case (op_q)
			OP_ALLOC: bsel = lowbit(~row & gmask);
			OP_NEXT:  bsel = lowbit(row & bitmask);
			default:  bsel = b_q;
		endcase
	end

	// Write-back of the row and the summaries in the final cycle.
	assign gbit = 64'd1 << g_q;
	always_comb begin
		new_word    = word_q;
		full_nx     = full_q;
		nonempty_nx = nonempty_q;
		if (op_q == OP_ALLOC) begin
			new_word    = word_q | (64'd1 << b_q);
			nonempty_nx = nonempty_q | gbit;
			if (new_word == gmask) begin
				full_nx = full_q | gbit;
			end
		end else if (op_q == OP_REMOVE) begin
			new_word = word_q & ~(64'd1 << b_q);
			full_nx  = full_q & ~gbit;
			if (new_word == 64'd0) begin
				nonempty_nx = nonempty_q & ~gbit;
			end
		end
	end

	assign bmp_we = (st_q == ST_DAT) && (op_q == OP_ALLOC || op_q == OP_REMOVE);
	assign dat_we = (st_q == ST_DAT) && (op_q == OP_ALLOC || op_q == OP_REPLACE);
	assign dat_wa = {g_q, b_q};

	always_ff @(posedge clk) begin
		if (bmp_re) begin
			bmp_rd_s2 <= bmp_mem[bmp_ra[GW-1:0]];
			bmp_v_s2  <= row_vld_q[bmp_ra[GW-1:0]];
		end
		if (bmp_we) begin
			bmp_mem[g_q[GW-1:0]] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (dat_re) begin
			dat_rd_s3 <= dat_mem[dat_ra[IDW-1:0]];
		end
		if (dat_we) begin
			dat_mem[dat_wa[IDW-1:0]] <= din_q;
		end
	end

	// Memory read requests are issued from the sequencer below.
	always_comb begin
		bmp_re = 1'b0;
		bmp_ra = g_q;
		dat_re = 1'b0;
		dat_ra = {g_q, bsel};
		case (st_q)
			ST_SUM: begin
				bmp_re = 1'b1;
				case (op_q)
					OP_ALLOC: bmp_ra = lowbit(free_grp);
					OP_NEXT:  bmp_ra = nstart[11:6];
					default:  bmp_ra = id_q[11:6];
				endcase
			end
			ST_BMP: begin
				if (op_q == OP_NEXT && (row & bitmask) == 64'd0) begin
					bmp_re = 1'b1;
					bmp_ra = lowbit(ne_above);
				end else begin
					dat_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			done_q      <= 1'b0;
			full_q      <= 64'd0;
			nonempty_q  <= 64'd0;
			row_vld_q   <= '0;
			second_q    <= 1'b0;
			status_q    <= STAT_OK;
			id_out_q    <= 12'd0;
			data_out_q  <= 32'd0;
			hit_q       <= 1'b0;
			now_empty_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						op_q     <= operation;
						id_q     <= id;
						din_q    <= data;
						second_q <= 1'b0;
						st_q     <= ST_SUM;
					end
				end
				ST_SUM: begin
					// Results that need no memory access are given here.
					status_q    <= STAT_OK;
					id_out_q    <= 12'd0;
					data_out_q  <= 32'd0;
					hit_q       <= 1'b0;
					now_empty_q <= (nonempty_q == 64'd0);
					g_q         <= bmp_ra;
					case (op_q)
						OP_ALLOC: begin
							if (free_grp == 64'd0) begin
								status_q <= STAT_FULL;
								done_q   <= 1'b1;
								st_q     <= ST_IDLE;
							end else begin
								st_q <= ST_BMP;
							end
						end
						OP_REMOVE, OP_FIND, OP_REPLACE: begin
							b_q <= id_q[5:0];
							if (!in_range) begin
								status_q <= STAT_RANGE;
								done_q   <= 1'b1;
								st_q     <= ST_IDLE;
							end else begin
								st_q <= ST_BMP;
							end
						end
						OP_NEXT: begin
							b_q <= nstart[5:0];
							if (!nstart_ok) begin
								status_q <= STAT_NONE;
								done_q   <= 1'b1;
								st_q     <= ST_IDLE;
							end else begin
								st_q <= ST_BMP;
							end
						end
						OP_CLEAR: begin
							full_q      <= 64'd0;
							nonempty_q  <= 64'd0;
							row_vld_q   <= '0;
							now_empty_q <= 1'b1;
							done_q      <= 1'b1;
							st_q        <= ST_IDLE;
						end
						default: begin
							status_q <= STAT_NONE;
							done_q   <= 1'b1;
							st_q     <= ST_IDLE;
						end
					endcase
				end
				ST_BMP: begin
					word_q <= row;
					b_q    <= bsel;
					if (op_q == OP_NEXT && (row & bitmask) == 64'd0) begin
						// Nothing left in this row: move to the next non-empty group, or report none.
						if (second_q || ne_above == 64'd0) begin
							status_q <= STAT_NONE;
							done_q   <= 1'b1;
							st_q     <= ST_IDLE;
						end else begin
							g_q      <= bmp_ra;
							b_q      <= 6'd0;
							second_q <= 1'b1;
						end
					end else if (op_q != OP_ALLOC && op_q != OP_NEXT && !row[b_q]) begin
						status_q <= STAT_NONE;
						done_q   <= 1'b1;
						st_q     <= ST_IDLE;
					end else begin
						st_q <= ST_DAT;
					end
				end
				ST_DAT: begin
					full_q      <= full_nx;
					nonempty_q  <= nonempty_nx;
					now_empty_q <= (nonempty_nx == 64'd0);
					if (bmp_we) begin
						row_vld_q[g_q[GW-1:0]] <= 1'b1;
					end
					status_q <= STAT_OK;
					done_q   <= 1'b1;
					st_q     <= ST_IDLE;
					case (op_q)
						OP_ALLOC: begin
							id_out_q   <= {g_q, b_q};
							data_out_q <= din_q;
							hit_q      <= 1'b0;
						end
						OP_NEXT: begin
							id_out_q   <= {g_q, b_q};
							data_out_q <= dat_rd_s3;
							hit_q      <= 1'b1;
						end
						default: begin
							id_out_q   <= 12'd0;
							data_out_q <= dat_rd_s3;
							hit_q      <= 1'b1;
						end
					endcase
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (st_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign id_out    = id_out_q;
	assign data_out  = data_out_q;
	assign hit       = hit_q;
	assign now_empty = now_empty_q;

endmodule

FILE: sv/ira_checker.sv
module ira_checker
	import ira_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [11:0] id_out,
	input logic [31:0] data_out,
	input logic        hit
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_FULL |-> id_out == 12'd0 && data_out == 32'd0 && !hit)
		else $error("full result carries payload");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> status == STAT_OK)
		else $error("hit with a failing status");

endmodule

bind id_radix_allocator ira_checker u_ira_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.id_out   (id_out),
	.data_out (data_out),
	.hit      (hit)
);

FILE: bench/id_radix_allocator_tb.sv
module id_radix_allocator_tb;
	import ira_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_IDS     = 4096;
	localparam int NUM_GROUPS  = NUM_IDS / GROUP_SIZE;
	localparam int FILL_WORDS  = 300;
	localparam int RANDOM_WORDS = 1300;
	localparam int CYCLE_LIMIT = 400000;

	// Outcome of one request, one field per result port.
	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] id_out;
		logic [31:0] data_out;
		logic        hit;
		logic        now_empty;
	} outcome_t;

	// One row of the directed table. When has_fixed is set, the typed-in outcome
	// must agree with the predictor as well as with the block.
	typedef struct {
		logic [2:0]  op;
		logic [12:0] id;
		logic [31:0] data;
		bit          has_fixed;
		outcome_t    fixed;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [12:0] id;
	logic [31:0] data;
	logic        done;
	logic [1:0]  status;
	logic [11:0] id_out;
	logic [31:0] data_out;
	logic        hit;
	logic        now_empty;

	id_radix_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.id        (id),
		.data      (data),
		.done      (done),
		.status    (status),
		.id_out    (id_out),
		.data_out  (data_out),
		.hit       (hit),
		.now_empty (now_empty)
	);

	// The bench keeps its own picture of the allocator: one used bit per ID and
	// the data word stored with each. The summary words of the block are only a
	// faster way to search the same bitmap, so a flat bitmap predicts them.
	bit        id_used [NUM_IDS];
	bit [31:0] id_word [NUM_IDS];
	int        used_count;

	outcome_t pending_outcomes[$];
	outcome_t last_outcome;   // outcome of the word most recently taken
	int       errors;
	int       cycles;
	bit       calm;   // set for the last stretch of the run, when nobody idles

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out what the block must answer to one request and updates the
	// bench's copy of the state the way the block updates its own.
	function automatic outcome_t predict_request(logic [2:0] op, logic [12:0] rid,
			logic [31:0] word);
		outcome_t r;
		int       sid;
		int       from;
		r   = '0;
		sid = $signed(rid);
		case (op)
			OP_ALLOC: begin
				r.status = STAT_FULL;
				for (int i = 0; i < NUM_IDS; i++) begin
					if (!id_used[i]) begin
						id_used[i] = 1'b1;
						id_word[i] = word;
						used_count++;
						r.status   = STAT_OK;
						r.id_out   = 12'(i);
						r.data_out = word;
						break;
					end
				end
			end
			OP_REMOVE, OP_FIND, OP_REPLACE: begin
				if (sid < 0 || sid >= NUM_IDS) begin
					r.status = STAT_RANGE;
				end else if (!id_used[sid]) begin
					r.status = STAT_NONE;
				end else begin
					r.hit      = 1'b1;
					r.data_out = id_word[sid];
					if (op == OP_REMOVE) begin
						id_used[sid] = 1'b0;
						used_count--;
					end else if (op == OP_REPLACE) begin
						id_word[sid] = word;
					end
				end
			end
			OP_NEXT: begin
				// Any start below -1 behaves like -1, so the search begins at zero.
				from = (sid < -1) ? 0 : sid + 1;
				r.status = STAT_NONE;
				for (int i = from; i < NUM_IDS; i++) begin
					if (id_used[i]) begin
						r.status   = STAT_OK;
						r.hit      = 1'b1;
						r.id_out   = 12'(i);
						r.data_out = id_word[i];
						break;
					end
				end
			end
			OP_CLEAR: begin
				// Data words are kept; they are only read again after a new alloc.
				for (int i = 0; i < NUM_IDS; i++) begin
					id_used[i] = 1'b0;
				end
				used_count = 0;
			end
			default: begin
				r.status = STAT_NONE;
			end
		endcase
		r.now_empty = (used_count == 0);
		return r;
	endfunction

	// Waits a random burst of idle cycles now and then, but never in the calm
	// stretch at the end. start is dropped so the last word is not taken again.
	task automatic sender_gap();
		if (!calm && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(10, 1)) @(posedge clk);
		end
	endtask

	// Presents one word and holds it until the block takes it. start stays high
	// across back-to-back words and is only dropped for a gap or at the end.
	task automatic send_word(logic [2:0] op, logic [12:0] rid, logic [31:0] word);
		operation <= op;
		id        <= rid;
		data      <= word;
		start     <= 1'b1;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		// The word was taken at this edge, so its outcome is due from now on.
		last_outcome = predict_request(op, rid, word);
		pending_outcomes.push_back(last_outcome);
		if (!calm && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(10, 1)) @(posedge clk);
		end
	endtask

	// Each strobe is compared with the oldest outcome still waiting.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no request waiting: status %0d id_out %0d", status,
					id_out);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (id_out !== want.id_out) begin
					$error("id_out: expected %0d, got %0d", want.id_out, id_out);
					errors++;
				end
				if (data_out !== want.data_out) begin
					$error("data_out: expected %h, got %h", want.data_out, data_out);
					errors++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					errors++;
				end
				if (now_empty !== want.now_empty) begin
					$error("now_empty: expected %0d, got %0d", want.now_empty, now_empty);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Picks an ID that is mostly allocated, so remove, find and replace hit
	// often, with some free and some out-of-range IDs mixed in.
	function automatic logic [12:0] pick_id();
		int tries;
		case ($urandom_range(9))
			0:       return 13'($urandom_range(8191, 4096));   // negative or beyond the top
			1:       return 13'($urandom_range(NUM_IDS - 1));
			default: begin
				for (tries = 0; tries < 8; tries++) begin
					int c;
					c = $urandom_range(used_count > 200 ? NUM_IDS - 1 : 255);
					if (id_used[c]) begin
						return 13'(c);
					end
				end
				return 13'($urandom_range(255));
			end
		endcase
	endfunction

	initial begin
		row_t        rows[$];
		outcome_t    got;
		logic [2:0]  op;
		int          sel;

		errors     = 0;
		cycles     = 0;
		calm       = 1'b0;
		used_count = 0;
		foreach (id_used[i]) begin
			id_used[i] = 1'b0;
			id_word[i] = '0;
		end
		arst_n    = 1'b0;
		start     = 1'b0;
		operation = OP_ALLOC;
		id        = '0;
		data      = '0;

		// Directed rows. Empty-state answers, range errors, unused codes and the first
		// allocs are written out; rows whose answer depends on history are predicted.
		rows.push_back('{OP_FIND,    13'd0,    32'h0,        1, '{STAT_NONE, 0, 0, 0, 1}});
		rows.push_back('{OP_NEXT,    13'h1FFF, 32'h0,        1, '{STAT_NONE, 0, 0, 0, 1}});
		rows.push_back('{OP_REPLACE, 13'd5,    32'hFFFFFFFF, 1, '{STAT_NONE, 0, 0, 0, 1}});
		rows.push_back('{OP_ALLOC,   13'd0,    32'hFFFFFFFF, 1,
			'{STAT_OK, 12'd0, 32'hFFFFFFFF, 0, 0}});
		rows.push_back('{OP_ALLOC,   13'h1FFF, 32'h0,        1, '{STAT_OK, 12'd1, 0, 0, 0}});
		rows.push_back('{OP_ALLOC,   13'h0AAA, 32'hA5A5A5A5, 1,
			'{STAT_OK, 12'd2, 32'hA5A5A5A5, 0, 0}});
		rows.push_back('{OP_REMOVE,  13'h1FFF, 32'h0,        1, '{STAT_RANGE, 0, 0, 0, 0}});
		rows.push_back('{OP_FIND,    13'd4096, 32'h0,        1, '{STAT_RANGE, 0, 0, 0, 0}});
		rows.push_back('{OP_REPLACE, 13'h1000, 32'h1,        1, '{STAT_RANGE, 0, 0, 0, 0}});
		rows.push_back('{3'd6,       13'd1,    32'h5,        1, '{STAT_NONE, 0, 0, 0, 0}});
		rows.push_back('{3'd7,       13'h1555, 32'h5A5A5A5A, 1, '{STAT_NONE, 0, 0, 0, 0}});
		rows.push_back('{OP_REPLACE, 13'd1,    32'h12345678, 0, '0});
		rows.push_back('{OP_FIND,    13'd1,    32'h0,        0, '0});
		rows.push_back('{OP_NEXT,    13'h1000, 32'h0,        0, '0});  // far below -1
		rows.push_back('{OP_NEXT,    13'd0,    32'h0,        0, '0});
		rows.push_back('{OP_REMOVE,  13'd1,    32'h0,        0, '0});
		rows.push_back('{OP_ALLOC,   13'd0,    32'h00C0FFEE, 0, '0});  // reuses the hole
		rows.push_back('{OP_NEXT,    13'd2,    32'h0,        0, '0});  // nothing above
		rows.push_back('{OP_NEXT,    13'd4095, 32'h0,        0, '0});
		rows.push_back('{OP_REMOVE,  13'd4095, 32'h0,        0, '0});
		rows.push_back('{OP_CLEAR,   13'd0,    32'h0,        1, '{STAT_OK, 0, 0, 0, 1}});
		rows.push_back('{OP_FIND,    13'd2,    32'h0,        1, '{STAT_NONE, 0, 0, 0, 1}});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].op, rows[i].id, rows[i].data);
			got = last_outcome;
			if (rows[i].has_fixed && got !== rows[i].fixed) begin
				$error("table row %0d: expected %h, predicted %h", i, rows[i].fixed, got);
				errors++;
			end
		end

		// Fill several groups so searches and allocs cross group boundaries,
		// then punch a few holes and refill them.
		for (int i = 0; i < FILL_WORDS; i++) begin
			send_word(OP_ALLOC, 13'($urandom), $urandom);
		end
		send_word(OP_ALLOC, 13'd0, $urandom);
		for (int i = 0; i < 40; i++) begin
			send_word(OP_REMOVE, 13'($urandom_range(FILL_WORDS - 1)), 32'h0);
		end
		send_word(OP_NEXT, 13'd4094, 32'h0);
		for (int i = 0; i < 40; i++) begin
			send_word(OP_ALLOC, 13'($urandom), $urandom);
		end
		for (int i = 0; i < 60; i++) begin
			send_word(OP_NEXT, 13'($urandom_range(FILL_WORDS + 63)), 32'h0);
		end
		send_word(OP_CLEAR, 13'($urandom), $urandom);

		// Random mix, weighted toward alloc so the map fills and searches cross
		// group boundaries; clear is rare so long histories build up.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS - 300) begin
				calm = 1'b1;
			end
			sel = $urandom_range(99);
			if (sel < 35) begin
				op = OP_ALLOC;
			end else if (sel < 50) begin
				op = OP_REMOVE;
			end else if (sel < 65) begin
				op = OP_FIND;
			end else if (sel < 77) begin
				op = OP_REPLACE;
			end else if (sel < 95) begin
				op = OP_NEXT;
			end else if (sel < 97) begin
				op = 3'($urandom_range(7, 6));
			end else if (sel == 97) begin
				op = OP_CLEAR;
			end else begin
				op = OP_ALLOC;
			end
			sender_gap();
			send_word(op, pick_id(), $urandom);
		end
		start <= 1'b0;

		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_outcomes.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/ira_pkg.sv
sv/id_radix_allocator.sv
sv/ira_checker.sv
bench/id_radix_allocator_tb.sv
